// File: hdl/pdr_pkg.sv
// Shared constants, types and arithmetic helpers for the planar dead reckoning block.
package pdr_pkg;

  localparam int FRACTION_BITS  = 16;
  localparam int ROTATION_STEPS = 16;

  // shared multiplier
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  // CORDIC
  localparam int Z_W          = 34;
  localparam int ITER_W       = $clog2(ROTATION_STEPS);
  localparam int CORDIC_GAIN  = 652032874;
  localparam int ACCEL_GAIN   = 164584489;
  localparam int ACC_SHIFT    = 38 - FRACTION_BITS;
  localparam int ANGLE_SHIFT  = 30;
  localparam int TIME_SHIFT   = 16;

  // encoder turn: radians to binary angle
  localparam int TURN_K      = 2670177;
  localparam int TURN_SHIFT  = FRACTION_BITS + 24;
  localparam int TURN_W      = FRACTION_BITS + 40;
  localparam int TURN_LO_W   = TURN_W / 2;
  localparam int TURN_HI_W   = TURN_W - TURN_LO_W;

  // square root
  localparam int SQ_ROOT_W = 21;
  localparam int SQ_IN_W   = 2 * SQ_ROOT_W;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W);

  localparam logic signed [31:0] POS_RESET = 32'(64'd15 << FRACTION_BITS);

  // ports
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 112;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [1:0] {
    OP_IMU      = 2'd0,
    OP_ENC      = 2'd1,
    OP_SET_POSE = 2'd2,
    OP_RST_VEL  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WB   = 3'd4;

  typedef enum logic [4:0] {
    STP_NOP,
    STP_ACC_F, STP_ACC_L, STP_ACC_D,
    STP_AE1, STP_AE2, STP_AN1, STP_AN2,
    STP_VE1, STP_VE2, STP_VN1, STP_VN2,
    STP_SQ1, STP_SQ2, STP_PE, STP_PN, STP_PD, STP_SQW,
    STP_EN0, STP_EN1, STP_EN2, STP_EN3, STP_EN4, STP_EN5,
    STP_ES, STP_EC, STP_ED,
    STP_SET, STP_RSTV
  } step_t;

  typedef struct packed {
    step_t step;
    logic  accept;
    logic  load_out;
  } pdr_cmd_t;

  typedef struct packed {
    logic cordic_busy;
    logic sqrt_busy;
  } pdr_status_t;

  // round half up then floor shift
  function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] v,
                                                   input int n);
    logic signed [PROD_W-1:0] half;
    half = signed'(PROD_W'(1)) <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [PROD_W-1:0] mag(input logic signed [PROD_W-1:0] v);
    return v[PROD_W-1] ? -v : v;
  endfunction

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [Z_W-1:0] atan_turn(input logic [4:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:  r = Z_W'(536870912);
      5'd1:  r = Z_W'(316933406);
      5'd2:  r = Z_W'(167458908);
      5'd3:  r = Z_W'(85004755);
      5'd4:  r = Z_W'(42667332);
      5'd5:  r = Z_W'(21354465);
      5'd6:  r = Z_W'(10679839);
      5'd7:  r = Z_W'(5340245);
      5'd8:  r = Z_W'(2670163);
      5'd9:  r = Z_W'(1335087);
      5'd10: r = Z_W'(667544);
      5'd11: r = Z_W'(333772);
      5'd12: r = Z_W'(166886);
      5'd13: r = Z_W'(83443);
      5'd14: r = Z_W'(41722);
      5'd15: r = Z_W'(20861);
      5'd16: r = Z_W'(10430);
      5'd17: r = Z_W'(5215);
      5'd18: r = Z_W'(2608);
      5'd19: r = Z_W'(1304);
      5'd20: r = Z_W'(652);
      5'd21: r = Z_W'(326);
      5'd22: r = Z_W'(163);
      5'd23: r = Z_W'(81);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/pdr_cordic.sv
// Iterative CORDIC unit: sine and cosine of a 16-bit binary angle, one rotation per cycle.
module pdr_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [15:0]                  angle,
  output logic                         busy,
  output logic signed [pdr_pkg::MUL_W-1:0] sin_q,
  output logic signed [pdr_pkg::MUL_W-1:0] cos_q
);
  import pdr_pkg::*;

  localparam logic signed [Z_W-1:0] QUARTER = Z_W'(64'd1073741824);
  localparam logic signed [Z_W-1:0] HALF    = Z_W'(64'd2147483648);
  localparam logic signed [Z_W-1:0] FULL    = Z_W'(64'd4294967296);

  logic signed [MUL_W-1:0] x, y;
  logic signed [Z_W-1:0]   z;
  logic [ITER_W-1:0]       iter;
  logic                    neg;

  logic signed [Z_W-1:0] z0, z1;
  logic                  neg0;
  logic signed [MUL_W-1:0] dx, dy;

  always_comb begin
    z0 = signed'(Z_W'({angle, 16'b0}));
    if (z0 >= HALF) z0 = z0 - FULL;
    neg0 = 1'b0;
    z1   = z0;
    // fold into [-quarter, +quarter] turn
    if (z0 > QUARTER) begin
      z1   = z0 - HALF;
      neg0 = 1'b1;
    end else if (z0 < -QUARTER) begin
      z1   = z0 + HALF;
      neg0 = 1'b1;
    end
    dx = y >>> iter;
    dy = x >>> iter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && iter == ITER_W'(ROTATION_STEPS - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= MUL_W'(CORDIC_GAIN);
      y    <= '0;
      z    <= z1;
      neg  <= neg0;
      iter <= '0;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_turn(5'(iter));
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_turn(5'(iter));
      end
      iter <= iter + 1'b1;
    end
  end

  assign sin_q = neg ? -y : y;
  assign cos_q = neg ? -x : x;

endmodule

// File: hdl/pdr_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module pdr_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pdr_pkg::SQ_IN_W-1:0]    radicand,
  output logic                           busy,
  output logic [pdr_pkg::SQ_ROOT_W-1:0]  root
);
  import pdr_pkg::*;

  logic [SQ_IN_W-1:0]  v;
  logic [SQ_REM_W-1:0] rem;
  logic [SQ_CNT_W-1:0] cnt;
  logic [SQ_REM_W-1:0] rem_s, trial;

  always_comb begin
    rem_s = {rem[SQ_REM_W-3:0], v[SQ_IN_W-1 -: 2]};
    trial = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == SQ_CNT_W'(SQ_ROOT_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      if (rem_s >= trial) begin
        rem  <= rem_s - trial;
        root <= {root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_s;
        root <= {root[SQ_ROOT_W-2:0], 1'b0};
      end
      v   <= v << 2;
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// File: hdl/pdr_datapath.sv
// Datapath: pose and velocity state, configuration, shared multiplier, CORDIC and root units.
module pdr_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  pdr_pkg::pdr_cmd_t               cmd,
  output pdr_pkg::pdr_status_t            status,
  input  logic                            cfg_we,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [pdr_pkg::IN_DATA_W-1:0]   in_data,
  output logic [pdr_pkg::OUT_DATA_W-1:0]  out_data
);
  import pdr_pkg::*;

  // configuration
  logic [19:0] accel_deadband, speed_limit;
  logic [16:0] velocity_decay;
  logic [30:0] map_extent;
  logic [23:0] inverse_wheel_base;

  // latched request
  logic signed [15:0] raw_fwd, raw_left;
  logic [15:0]        in_head, dt;
  logic signed [31:0] l_trav, r_trav, new_e, new_n;

  // state
  logic signed [31:0] pos_e, pos_n, vel_e, vel_n;
  logic [15:0]        head;
  logic [30:0]        speed;

  // scratch
  logic signed [MUL_W-1:0]  fwd, left, ae, an, mid_trav, diff;
  logic [TURN_W-1:0]        turn_p;
  logic [15:0]              turn;
  logic signed [PROD_W-1:0] acc, prod;

  logic signed [MUL_W-1:0]  mul_a, mul_b, sin_q, cos_q;
  logic signed [PROD_W-1:0] mul_p;
  logic                     cordic_start, sqrt_start;
  logic [15:0]              cordic_angle;
  logic [SQ_ROOT_W-1:0]     root;

  logic signed [PROD_W-1:0] r_acc, db_val, ae_sum, an_sum, r16, v_sum, v_lim;
  logic signed [PROD_W-1:0] pos_sel, p_imu, p_imu_c, p_enc, p_enc_s, sq_sum;
  logic [TURN_W-1:0]        turn_sum;
  logic signed [32:0]       wsum, wdiff;

  logic signed [MUL_W-1:0] dt_x, decay_x, iwb_x, k_x;

  assign dt_x    = signed'(MUL_W'(dt));
  assign decay_x = signed'(MUL_W'(velocity_decay));
  assign iwb_x   = signed'(MUL_W'(inverse_wheel_base));
  assign k_x     = MUL_W'(TURN_K);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      STP_ACC_F: begin mul_a = MUL_W'(raw_fwd);  mul_b = MUL_W'(ACCEL_GAIN); end
      STP_ACC_L: begin mul_a = MUL_W'(raw_left); mul_b = MUL_W'(ACCEL_GAIN); end
      STP_AE1:   begin mul_a = fwd;  mul_b = sin_q; end
      STP_AE2:   begin mul_a = left; mul_b = cos_q; end
      STP_AN1:   begin mul_a = fwd;  mul_b = cos_q; end
      STP_AN2:   begin mul_a = left; mul_b = sin_q; end
      STP_VE1:   begin mul_a = MUL_W'(vel_e); mul_b = decay_x; end
      STP_VE2:   begin mul_a = ae; mul_b = dt_x; end
      STP_VN1:   begin mul_a = MUL_W'(vel_n); mul_b = decay_x; end
      STP_VN2:   begin mul_a = an; mul_b = dt_x; end
      STP_SQ1:   begin mul_a = MUL_W'(vel_e); mul_b = MUL_W'(vel_e); end
      STP_SQ2:   begin mul_a = MUL_W'(vel_n); mul_b = MUL_W'(vel_n); end
      STP_PE:    begin mul_a = MUL_W'(vel_e); mul_b = dt_x; end
      STP_PN:    begin mul_a = MUL_W'(vel_n); mul_b = dt_x; end
      STP_EN1:   begin mul_a = diff; mul_b = iwb_x; end
      STP_EN3:   begin mul_a = signed'(MUL_W'(turn_p[TURN_LO_W-1:0])); mul_b = k_x; end
      STP_EN4:   begin mul_a = signed'(MUL_W'(turn_p[TURN_W-1:TURN_LO_W])); mul_b = k_x; end
      STP_ES:    begin mul_a = mid_trav; mul_b = sin_q; end
      STP_EC:    begin mul_a = mid_trav; mul_b = cos_q; end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    r_acc   = rnd(prod, ACC_SHIFT);
    db_val  = (mag(r_acc) < signed'(PROD_W'(accel_deadband))) ? '0 : r_acc;
    ae_sum  = rnd(acc + prod, ANGLE_SHIFT);
    an_sum  = rnd(acc - prod, ANGLE_SHIFT);
    r16     = rnd(prod, TIME_SHIFT);
    v_sum   = acc + r16;
    v_lim   = (mag(v_sum) > signed'(PROD_W'(speed_limit))) ? '0 : v_sum;
    sq_sum  = acc + prod;
    pos_sel = (cmd.step == STP_PD || cmd.step == STP_ED) ? PROD_W'(pos_n) : PROD_W'(pos_e);
    p_imu   = pos_sel + r16;
    p_imu_c = p_imu;
    if (p_imu < 0) p_imu_c = '0;
    else if (p_imu > signed'(PROD_W'(map_extent))) p_imu_c = signed'(PROD_W'(map_extent));
    p_enc   = pos_sel + rnd(prod, ANGLE_SHIFT);
    p_enc_s = p_enc;
    if (p_enc > signed'(PROD_W'(32'h7FFF_FFFF))) p_enc_s = signed'(PROD_W'(32'h7FFF_FFFF));
    else if (p_enc < -signed'(PROD_W'(33'h1_0000_0000 >> 1)))
      p_enc_s = -signed'(PROD_W'(33'h1_0000_0000 >> 1));
    turn_sum = TURN_W'(acc) + (TURN_W'(prod) << TURN_LO_W) + (TURN_W'(1) << (TURN_SHIFT - 1));
    wsum     = 33'(l_trav) + 33'(r_trav);
    wdiff    = 33'(r_trav) - 33'(l_trav);
  end

  assign cordic_start = (cmd.step == STP_ACC_F) || (cmd.step == STP_EN0);
  assign cordic_angle = (cmd.step == STP_ACC_F) ? in_head : head;
  assign sqrt_start   = (cmd.step == STP_PE);

  pdr_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (cordic_angle),
    .busy  (status.cordic_busy),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  pdr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq_sum[SQ_IN_W-1:0]),
    .busy     (status.sqrt_busy),
    .root     (root)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_deadband     <= 20'd9830;
      speed_limit        <= 20'd131072;
      velocity_decay     <= 17'd65208;
      map_extent         <= 31'd1966080;
      inverse_wheel_base <= 24'd327680;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEADBAND: accel_deadband     <= cfg_data[19:0];
        REG_SPEED:    speed_limit        <= cfg_data[19:0];
        REG_DECAY:    velocity_decay     <= cfg_data[16:0];
        REG_MAP:      map_extent         <= cfg_data[30:0];
        REG_INV_WB:   inverse_wheel_base <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // request capture, scratch and product registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (cmd.accept) begin
      raw_fwd  <= signed'(in_data[15:0]);
      raw_left <= signed'(in_data[31:16]);
      in_head  <= in_data[47:32];
      dt       <= in_data[63:48];
      l_trav   <= signed'(in_data[95:64]);
      r_trav   <= signed'(in_data[127:96]);
      new_e    <= signed'(in_data[159:128]);
      new_n    <= signed'(in_data[191:160]);
    end
    case (cmd.step)
      STP_ACC_L: fwd  <= MUL_W'(db_val);
      STP_ACC_D: left <= MUL_W'(db_val);
      STP_AE2:   acc  <= prod;
      STP_AN1:   ae   <= MUL_W'(ae_sum);
      STP_AN2:   acc  <= prod;
      STP_VE1:   an   <= MUL_W'(an_sum);
      STP_VE2:   acc  <= r16;
      STP_VN2:   acc  <= r16;
      STP_SQ2:   acc  <= prod;
      STP_EN0: begin
        mid_trav <= MUL_W'(wsum >>> 1);
        diff     <= MUL_W'(wdiff);
      end
      STP_EN2:   turn_p <= TURN_W'(prod);
      STP_EN4:   acc    <= prod;
      STP_EN5:   turn   <= turn_sum[TURN_W-1 -: 16];
      default: ;
    endcase
  end

  // pose, velocity and speed
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_e <= POS_RESET;
      pos_n <= POS_RESET;
      head  <= '0;
      vel_e <= '0;
      vel_n <= '0;
      speed <= '0;
    end else begin
      case (cmd.step)
        STP_ACC_F: head  <= in_head;
        STP_VN1:   vel_e <= 32'(v_lim);
        STP_SQ1:   vel_n <= 32'(v_lim);
        STP_PN:    pos_e <= 32'(p_imu_c);
        STP_PD:    pos_n <= 32'(p_imu_c);
        STP_SQW:   speed <= 31'(root);
        STP_EC:    pos_e <= 32'(p_enc_s);
        STP_ED: begin
          pos_n <= 32'(p_enc_s);
          head  <= head + turn;
        end
        STP_SET: begin
          pos_e <= new_e;
          pos_n <= new_n;
          head  <= in_head;
        end
        STP_RSTV: begin
          vel_e <= '0;
          vel_n <= '0;
          speed <= '0;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {1'b0, speed, head, pos_n, pos_e};
    end
  end

endmodule

// File: hdl/pdr_ctrl.sv
// Controller: sequences the datapath steps for each operation and runs the handshakes.
module pdr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  pdr_pkg::op_t          op,
  input  pdr_pkg::pdr_status_t  status,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output pdr_pkg::pdr_cmd_t     cmd
);
  import pdr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ACC_F, S_ACC_L, S_ACC_D, S_I_CW,
    S_AE1, S_AE2, S_AN1, S_AN2,
    S_VE1, S_VE2, S_VN1, S_VN2,
    S_SQ1, S_SQ2, S_PE, S_PN, S_PD, S_SQW,
    S_EN0, S_EN1, S_EN2, S_EN3, S_EN4, S_EN5, S_E_CW,
    S_ES, S_EC, S_ED,
    S_SET, S_RSTV, S_DONE
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next   = state;
    cmd.step     = STP_NOP;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          unique case (op)
            OP_IMU:      state_next = S_ACC_F;
            OP_ENC:      state_next = S_EN0;
            OP_SET_POSE: state_next = S_SET;
            OP_RST_VEL:  state_next = S_RSTV;
            default:     state_next = S_RSTV;
          endcase
        end
      end
      S_ACC_F: begin cmd.step = STP_ACC_F; state_next = S_ACC_L; end
      S_ACC_L: begin cmd.step = STP_ACC_L; state_next = S_ACC_D; end
      S_ACC_D: begin cmd.step = STP_ACC_D; state_next = S_I_CW; end
      S_I_CW:  if (!status.cordic_busy) state_next = S_AE1;
      S_AE1:   begin cmd.step = STP_AE1; state_next = S_AE2; end
      S_AE2:   begin cmd.step = STP_AE2; state_next = S_AN1; end
      S_AN1:   begin cmd.step = STP_AN1; state_next = S_AN2; end
      S_AN2:   begin cmd.step = STP_AN2; state_next = S_VE1; end
      S_VE1:   begin cmd.step = STP_VE1; state_next = S_VE2; end
      S_VE2:   begin cmd.step = STP_VE2; state_next = S_VN1; end
      S_VN1:   begin cmd.step = STP_VN1; state_next = S_VN2; end
      S_VN2:   begin cmd.step = STP_VN2; state_next = S_SQ1; end
      S_SQ1:   begin cmd.step = STP_SQ1; state_next = S_SQ2; end
      S_SQ2:   begin cmd.step = STP_SQ2; state_next = S_PE; end
      S_PE:    begin cmd.step = STP_PE;  state_next = S_PN; end
      S_PN:    begin cmd.step = STP_PN;  state_next = S_PD; end
      S_PD:    begin cmd.step = STP_PD;  state_next = S_SQW; end
      S_SQW: begin
        cmd.step = STP_SQW;
        if (!status.sqrt_busy) state_next = S_DONE;
      end
      S_EN0:   begin cmd.step = STP_EN0; state_next = S_EN1; end
      S_EN1:   begin cmd.step = STP_EN1; state_next = S_EN2; end
      S_EN2:   begin cmd.step = STP_EN2; state_next = S_EN3; end
      S_EN3:   begin cmd.step = STP_EN3; state_next = S_EN4; end
      S_EN4:   begin cmd.step = STP_EN4; state_next = S_EN5; end
      S_EN5:   begin cmd.step = STP_EN5; state_next = S_E_CW; end
      S_E_CW:  if (!status.cordic_busy) state_next = S_ES;
      S_ES:    begin cmd.step = STP_ES; state_next = S_EC; end
      S_EC:    begin cmd.step = STP_EC; state_next = S_ED; end
      S_ED:    begin cmd.step = STP_ED; state_next = S_DONE; end
      S_SET:   begin cmd.step = STP_SET;  state_next = S_DONE; end
      S_RSTV:  begin cmd.step = STP_RSTV; state_next = S_DONE; end
      S_DONE: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/planar_dead_reckoning_top.sv
// Planar dead reckoning: IMU and wheel-encoder pose tracking, one request at a time.
// IMU step: the time from request to result is set by the 16 CORDIC rotations and the
// 21-step square root; for an encoder step it is set by the CORDIC alone.
// The block is ready for the next request in the cycle after the result is loaded; a
// result held by the receiver stalls the input. Synchronous reset restores pose
// 15 m / 15 m, zero heading, velocity and speed and the default register values.
module planar_dead_reckoning_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // accel_forward, accel_left, heading_in, time_step, left_travel, right_travel,
  // new_east, new_north
  input  logic [pdr_pkg::IN_DATA_W-1:0]   s_tdata,
  // operation
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // east_position, north_position, heading_out, speed_out, one pad bit
  output logic [pdr_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pdr_pkg::*;

  pdr_cmd_t    cmd;
  pdr_status_t status;

  pdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (op_t'(s_tuser)),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  pdr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .out_data  (m_tdata)
  );

  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !status.cordic_busy && !status.sqrt_busy)
    else $error("request taken while an arithmetic unit is busy");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken before the first finished");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[110:101] == 10'd0)
    else $error("speed wider than the root unit allows");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for planar_dead_reckoning_top with a pose-tracking scoreboard.
module testbench;
  import pdr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 60;

  typedef struct {
    op_t                op;
    logic signed [15:0] acc_fwd;
    logic signed [15:0] acc_left;
    logic [15:0]        heading;
    logic [15:0]        dt;
    logic signed [31:0] left_mv;
    logic signed [31:0] right_mv;
    logic signed [31:0] east_ld;
    logic signed [31:0] north_ld;
  } pose_request_t;

  typedef struct {
    logic signed [31:0] east;
    logic signed [31:0] north;
    logic [15:0]        heading;
    logic [30:0]        speed;
  } pose_report_t;

  class pose_tracker;
    longint deadband_q, vlimit_q, decay_q, extent_q, inv_base_q;
    longint east_q, north_q, vel_e, vel_n;
    logic [15:0] head_q;
    logic [30:0] speed_q;
    pose_report_t pending[$];
    int errors;

    function new();
      deadband_q = 9830; vlimit_q = 131072; decay_q = 65208;
      extent_q = 1966080; inv_base_q = 327680;
      east_q = 983040; north_q = 983040; vel_e = 0; vel_n = 0;
      head_q = '0; speed_q = '0; errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DEADBAND: deadband_q = longint'(val[19:0]);
        REG_SPEED:    vlimit_q   = longint'(val[19:0]);
        REG_DECAY:    decay_q    = longint'(val[16:0]);
        REG_MAP:      extent_q   = longint'(val[30:0]);
        REG_INV_WB:   inv_base_q = longint'(val[23:0]);
        default: ;
      endcase
    endfunction

    function longint round_sh(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function longint absv(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // rotate the gain vector by the heading, folded to the right half-plane
    function void sincos(logic [15:0] h, output longint s, output longint c);
      longint angle_tbl[24];
      longint z, x, y, q, dx, dy;
      bit flip;
      angle_tbl = '{536870912, 316933406, 167458908, 85004755, 42667332, 21354465,
                    10679839, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      z = longint'({h, 16'h0000});
      x = 652032874;
      y = 0;
      q = longint'(1) <<< 30;
      flip = 0;
      if (z >= 2 * q) z = z - 4 * q;
      if (z > q) begin
        z = z - 2 * q; flip = 1;
      end else if (z < -q) begin
        z = z + 2 * q; flip = 1;
      end
      for (int i = 0; i < ROTATION_STEPS && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - angle_tbl[i];
        end else begin
          x = x + dx; y = y - dy; z = z + angle_tbl[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      s = y;
      c = x;
    endfunction

    function void note_request(pose_request_t r);
      longint fwd, lft, s, c, ae, an, ve, vn, dt, lw, rw, mid_mv;
      longint unsigned turn;
      pose_report_t rep;
      case (r.op)
        OP_IMU: begin
          head_q = r.heading;
          fwd = round_sh(longint'(r.acc_fwd) * 164584489, 38 - FRACTION_BITS);
          lft = round_sh(longint'(r.acc_left) * 164584489, 38 - FRACTION_BITS);
          if (absv(fwd) < deadband_q) fwd = 0;
          if (absv(lft) < deadband_q) lft = 0;
          sincos(head_q, s, c);
          ae = round_sh(fwd * s + lft * c, 30);
          an = round_sh(fwd * c - lft * s, 30);
          dt = longint'({48'h0, r.dt});
          ve = round_sh(vel_e * decay_q, 16) + round_sh(ae * dt, 16);
          vn = round_sh(vel_n * decay_q, 16) + round_sh(an * dt, 16);
          if (absv(ve) > vlimit_q) ve = 0;
          if (absv(vn) > vlimit_q) vn = 0;
          vel_e = longint'(int'(ve));
          vel_n = longint'(int'(vn));
          speed_q = 31'(root(longint'(ve * ve) + longint'(vn * vn)));
          east_q = east_q + round_sh(ve * dt, 16);
          north_q = north_q + round_sh(vn * dt, 16);
          // clamp to the map on IMU steps only
          if (east_q < 0) east_q = 0;
          if (east_q > extent_q) east_q = extent_q;
          if (north_q < 0) north_q = 0;
          if (north_q > extent_q) north_q = extent_q;
        end
        OP_ENC: begin
          lw = longint'(r.left_mv);
          rw = longint'(r.right_mv);
          mid_mv = (lw + rw) >>> 1;
          sincos(head_q, s, c);
          east_q = sat32(east_q + round_sh(mid_mv * s, 30));
          north_q = sat32(north_q + round_sh(mid_mv * c, 30));
          turn = longint'(rw - lw) * inv_base_q * 64'd2670177;
          turn = turn + (64'd1 << 39);
          head_q = head_q + 16'(turn >> 40);
        end
        OP_SET_POSE: begin
          east_q = longint'(r.east_ld);
          north_q = longint'(r.north_ld);
          head_q = r.heading;
        end
        default: begin
          vel_e = 0; vel_n = 0; speed_q = '0;
        end
      endcase
      rep.east = 32'(east_q);
      rep.north = 32'(north_q);
      rep.heading = head_q;
      rep.speed = speed_q;
      pending.push_back(rep);
    endfunction

    function void check_result(pose_report_t got);
      pose_report_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no pending request");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.east !== exp_r.east) begin
        $error("east_position expected %0d got %0d", exp_r.east, got.east);
        errors++;
      end
      if (got.north !== exp_r.north) begin
        $error("north_position expected %0d got %0d", exp_r.north, got.north);
        errors++;
      end
      if (got.heading !== exp_r.heading) begin
        $error("heading_out expected %0d got %0d", exp_r.heading, got.heading);
        errors++;
      end
      if (got.speed !== exp_r.speed) begin
        $error("speed_out expected %0d got %0d", exp_r.speed, got.speed);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pose_tracker sb = new();
  int cycles = 0;
  int sent = 0;
  int reports = 0;
  bit squeezed = 0;

  planar_dead_reckoning_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_regs(int deadband, int vlimit, int decay, int extent, int inv_base);
    write_cfg(REG_DEADBAND, CFG_DATA_W'(deadband));
    write_cfg(REG_SPEED, CFG_DATA_W'(vlimit));
    write_cfg(REG_DECAY, CFG_DATA_W'(decay));
    write_cfg(REG_MAP, CFG_DATA_W'(extent));
    write_cfg(REG_INV_WB, CFG_DATA_W'(inv_base));
  endtask

  // wait for every pending pose, then let the block settle
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_request(pose_request_t r);
    int gap;
    gap = ((sent % 64) < 16) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r.north_ld, r.east_ld, r.right_mv, r.left_mv, r.dt, r.heading,
                r.acc_left, r.acc_fwd};
    s_tuser <= r.op;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    sb.note_request(r);
    sent++;
  endtask

  task automatic send_op(op_t op, int af, int al, int hd, int dt,
                         int lt, int rt, int ne, int nn);
    pose_request_t r;
    r.op = op;
    r.acc_fwd = 16'(af); r.acc_left = 16'(al);
    r.heading = 16'(hd); r.dt = 16'(dt);
    r.left_mv = lt; r.right_mv = rt; r.east_ld = ne; r.north_ld = nn;
    send_request(r);
  endtask

  function automatic pose_request_t random_request();
    pose_request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.op = pick < 40 ? OP_IMU : pick < 70 ? OP_ENC : pick < 85 ? OP_SET_POSE : OP_RST_VEL;
    r.acc_fwd = $urandom_range(0, 2) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 8000) - 4000);
    r.acc_left = $urandom_range(0, 2) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 8000) - 4000);
    r.heading = 16'($urandom());
    r.dt = $urandom_range(0, 4) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 6554));
    r.left_mv = $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 524288) - 262144;
    r.right_mv = $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 524288) - 262144;
    r.east_ld = $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 2000000);
    r.north_ld = $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 2000000);
    return r;
  endfunction

  // result side: random stalls plus one long hold-off to back up the input
  initial begin
    pose_report_t got;
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ((reports % 50) < 12) ? 0 : $urandom_range(0, 12);
      if (!squeezed && reports == 150) begin
        stall = 400;
        squeezed = 1;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      got.east = m_tdata[31:0];
      got.north = m_tdata[63:32];
      got.heading = m_tdata[79:64];
      got.speed = m_tdata[110:80];
      sb.check_result(got);
      reports++;
      @(posedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_regs(9830, 131072, 65208, 1966080, 327680);

    // directed: field extremes, each operation, map clamp and 32-bit saturation
    send_op(OP_IMU, 32767, -32768, 0, 65535, 0, 0, 0, 0);
    send_op(OP_IMU, -32768, 32767, 16384, 65535, 0, 0, 0, 0);
    send_op(OP_IMU, 32767, 32767, 32768, 6554, 0, 0, 0, 0);
    send_op(OP_IMU, -32768, -32768, 49152, 0, 0, 0, 0, 0);
    send_op(OP_IMU, 100, -100, 65535, 3277, 0, 0, 0, 0);
    send_op(OP_RST_VEL, 0, 0, 0, 0, 0, 0, 0, 0);
    send_op(OP_SET_POSE, 0, 0, 8192, 0, 0, 0, -5, 3000000);
    send_op(OP_IMU, 20000, 0, 8192, 65535, 0, 0, 0, 0);
    send_op(OP_SET_POSE, 0, 0, 0, 0, 0, 0, 32'h7FFF0000, 32'h80010000);
    send_op(OP_ENC, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0);
    send_op(OP_ENC, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 0, 0);
    send_op(OP_ENC, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0, 0);
    send_op(OP_ENC, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0);
    send_op(OP_ENC, 0, 0, 0, 0, 65536, 131072, 0, 0);
    send_op(OP_ENC, 0, 0, 0, 0, -65536, 0, 0, 0);
    send_op(OP_SET_POSE, 0, 0, 65535, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF);
    send_op(OP_ENC, 0, 0, 0, 0, -1, -1, 0, 0);
    send_op(OP_IMU, 0, 0, 65535, 1000, 0, 0, 0, 0);
    send_op(OP_RST_VEL, 0, 0, 0, 0, 0, 0, 0, 0);
    s_tvalid <= 1'b0;
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: load_regs(0, 1048575, 65536, 32'h7FFFFFFF, 1);
        1: load_regs(1048575, 0, 0, 0, 16777215);
        2: load_regs(0, 1048575, 131071, 32'h7FFFFFFF, 0);
        default: load_regs($urandom_range(0, 30000), $urandom_range(10000, 1048575),
                           $urandom_range(60000, 65536), $urandom_range(0, 40000000),
                           $urandom_range(1, 16777215));
      endcase
      repeat (phase < 3 ? 40 : 85) send_request(random_request());
      s_tvalid <= 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
